/* src/rpp_pkg.sv */
`default_nettype none
package rpp_pkg;

    localparam int CH_BITS       = 6;
    localparam int CHANNELS      = 2 ** CH_BITS;
    localparam int SAMPLE_BITS   = 16;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS;
    localparam int SUM_BITS      = 48;
    localparam int CNT_BITS      = 16;
    localparam int ROOT_BITS     = SUM_BITS / 2;
    localparam int OUT_BITS      = 16;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEND_PEAK    = 1'b1;
    localparam logic [CNT_BITS-1:0]     DEFAULT_WINDOW   = 16'd10;

    localparam int DIV_STEPS_PER_CYCLE  = 4;
    localparam int DIV_CYCLES           = SUM_BITS / DIV_STEPS_PER_CYCLE;
    localparam int DIV_CNT_BITS         = $clog2(DIV_CYCLES);
    localparam int SQRT_STEPS_PER_CYCLE = 2;
    localparam int SQRT_CYCLES          = ROOT_BITS / SQRT_STEPS_PER_CYCLE;
    localparam int SQRT_CNT_BITS        = $clog2(SQRT_CYCLES);
    localparam int SQRT_REM_BITS        = ROOT_BITS + 2;

    typedef struct packed {
        logic [SUM_BITS-1:0]           sum;
        logic [CNT_BITS-1:0]           count;
        logic signed [SAMPLE_BITS-1:0] win_max;
        logic signed [SAMPLE_BITS-1:0] win_min;
    } t_entry;

    typedef struct packed {
        logic               en;
        logic [CH_BITS-1:0] addr;
        t_entry             data;
    } t_mem_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

/* src/rpp_in_if.sv */
`default_nettype none
interface rpp_in_if;
    import rpp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CH_BITS-1:0]            channel;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface
`default_nettype wire

/* src/rpp_out_if.sv */
`default_nettype none
interface rpp_out_if;
    import rpp_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_BITS-1:0]  channel_out;
    logic [OUT_BITS-1:0] rms_value;
    logic [OUT_BITS-1:0] peak_to_peak;

    modport source (output valid, output channel_out, output rms_value,
                    output peak_to_peak, input ready);
    modport sink   (input valid, input channel_out, input rms_value,
                    input peak_to_peak, output ready);
endinterface
`default_nettype wire

/* src/block_rms_peak_to_peak_core.sv */
// Per-channel block RMS with peak-to-peak.
// i_in carries one sample tagged with a channel (valid/ready, a transaction
// completes when both are high). The channel's sum of squares, sample count,
// maximum and minimum live in one 64-entry state memory with a registered
// read: the entry read on accept is updated and written back in ST_UPDATE.
// When the channel's count reaches sample_count, the mean of squares is
// formed by an iterative divider (4 quotient bits per cycle) and its integer
// root by an iterative square-root unit (2 root bits per cycle). The closing
// sample passes ST_UPDATE, ST_DIV and ST_SQRT, and ST_OUT loads the result
// into the o_out register; only then does the block take a new sample.
// One sample is in work at a time; i_in.ready is high whenever the block is
// free, also while a result waits in the output register.
// If o_out stalls, a finished result waits there; a following completed
// window holds in the block until that register is free.
// The user must write configuration (i_cfg_we/i_cfg_idx/i_cfg_data) only
// while idle; the block does not enforce it. Reset clears all channel sums
// and counts at once (valid bits), sets sample_count to 10, send_peak to 0.
`default_nettype none
module block_rms_peak_to_peak_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rpp_in_if.sink                            i_in,
    rpp_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rpp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import rpp_pkg::*;

    t_state                        r_state;
    t_state                        n_state;
    logic [CNT_BITS-1:0]           r_sample_count;
    logic                          r_send_peak;
    logic [CH_BITS-1:0]            r_ch;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [SQ_BITS-1:0]            r_sq;
    logic [OUT_BITS-1:0]           r_p2p;
    logic                          r_out_valid;
    logic [CH_BITS-1:0]            r_out_ch;
    logic [OUT_BITS-1:0]           r_out_rms;
    logic [OUT_BITS-1:0]           r_out_p2p;

    logic                          in_ready;
    logic                          upd_en;
    logic                          out_load;
    logic                          in_accept;
    logic signed [SQ_BITS-1:0]     prod;
    t_entry                        rd_entry;
    t_mem_wr                       mem_wr;
    logic [SUM_BITS-1:0]           sum_new;
    logic [CNT_BITS-1:0]           cnt_new;
    logic [CNT_BITS-1:0]           win_len;
    logic                          first;
    logic signed [SAMPLE_BITS-1:0] max_new;
    logic signed [SAMPLE_BITS-1:0] min_new;
    logic [SAMPLE_BITS:0]          diff;
    logic                          emit;
    logic                          div_done;
    logic [SUM_BITS-1:0]           quotient;
    logic                          sqrt_done;
    logic [ROOT_BITS-1:0]          root;
    logic [OUT_BITS-1:0]           rms_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= DEFAULT_WINDOW;
            r_send_peak    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CNT_BITS-1:0];
                CFG_SEND_PEAK:    r_send_peak    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_accept = i_in.valid && in_ready;
    assign prod      = i_in.sample * i_in.sample;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch     <= i_in.channel;
            r_sample <= i_in.sample;
            r_sq     <= unsigned'(prod);
        end
    end

    rpp_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (i_in.channel),
        .i_wr      (mem_wr),
        .o_rd_data (rd_entry)
    );

    // read-modify-write of the channel entry
    always_comb begin
        first   = (rd_entry.count == '0);
        sum_new = rd_entry.sum + SUM_BITS'(r_sq);
        cnt_new = rd_entry.count + 1'b1;
        max_new = (first || r_sample > rd_entry.win_max) ? r_sample : rd_entry.win_max;
        min_new = (first || r_sample < rd_entry.win_min) ? r_sample : rd_entry.win_min;
        win_len = (r_sample_count == '0) ? CNT_BITS'(1) : r_sample_count;
        emit    = (cnt_new >= win_len);
        diff    = {max_new[SAMPLE_BITS-1], max_new} - {min_new[SAMPLE_BITS-1], min_new};

        mem_wr.en           = upd_en;
        mem_wr.addr         = r_ch;
        mem_wr.data.sum     = emit ? '0 : sum_new;
        mem_wr.data.count   = emit ? '0 : cnt_new;
        mem_wr.data.win_max = max_new;
        mem_wr.data.win_min = min_new;
    end

    always_ff @(posedge i_clk) begin
        if (upd_en) begin
            r_p2p <= r_send_peak ? diff[OUT_BITS-1:0] : '0;
        end
    end

    rpp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (upd_en && emit),
        .i_dividend (sum_new),
        .i_divisor  (win_len),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    rpp_isqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_done),
        .i_radicand (quotient),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    assign rms_sat = (root[ROOT_BITS-1:OUT_BITS] != '0) ? '1 : root[OUT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = ST_UPDATE;
            ST_UPDATE: n_state = emit ? ST_DIV : ST_IDLE;
            ST_DIV:    if (div_done) n_state = ST_SQRT;
            ST_SQRT:   if (sqrt_done) n_state = ST_OUT;
            ST_OUT:    if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        upd_en   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE:   in_ready = 1'b1;
            ST_UPDATE: upd_en   = 1'b1;
            ST_OUT:    out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch  <= r_ch;
            r_out_rms <= rms_sat;
            r_out_p2p <= r_p2p;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.channel_out  = r_out_ch;
    assign o_out.rms_value    = r_out_rms;
    assign o_out.peak_to_peak = r_out_p2p;

endmodule
`default_nettype wire

/* src/rpp_state_mem.sv */
`default_nettype none
module rpp_state_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rpp_pkg::CH_BITS-1:0] i_rd_addr,
    input  rpp_pkg::t_mem_wr            i_wr,
    output rpp_pkg::t_entry             o_rd_data
);
    import rpp_pkg::*;

    t_entry               mem [CHANNELS];
    logic [CHANNELS-1:0]  r_valid;
    t_entry               r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // sum and count read as zero until the entry is first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.sum   = '0;
            o_rd_data.count = '0;
        end
    end

endmodule
`default_nettype wire

/* src/rpp_divider.sv */
`default_nettype none
module rpp_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rpp_pkg::SUM_BITS-1:0] i_dividend,
    input  logic [rpp_pkg::CNT_BITS-1:0] i_divisor,
    output logic                         o_done,
    output logic [rpp_pkg::SUM_BITS-1:0] o_quotient
);
    import rpp_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [SUM_BITS-1:0]     r_work;
    logic [CNT_BITS-1:0]     r_rem;
    logic [CNT_BITS-1:0]     r_div;
    logic [SUM_BITS-1:0]     n_work;
    logic [CNT_BITS-1:0]     n_rem;

    // restoring division; dividend bits leave the top of r_work, quotient bits enter below
    always_comb begin
        logic [CNT_BITS:0] t;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < DIV_STEPS_PER_CYCLE; k++) begin
            t      = {n_rem, n_work[SUM_BITS-1]};
            n_work = {n_work[SUM_BITS-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t         = t - {1'b0, r_div};
                n_work[0] = 1'b1;
            end
            n_rem = t[CNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule
`default_nettype wire

/* src/rpp_isqrt.sv */
`default_nettype none
module rpp_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rpp_pkg::SUM_BITS-1:0]  i_radicand,
    output logic                          o_done,
    output logic [rpp_pkg::ROOT_BITS-1:0] o_root
);
    import rpp_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [SQRT_CNT_BITS-1:0] r_cnt;
    logic [SUM_BITS-1:0]      r_rad;
    logic [SQRT_REM_BITS-1:0] r_rem;
    logic [ROOT_BITS-1:0]     r_root;
    logic [SUM_BITS-1:0]      n_rad;
    logic [SQRT_REM_BITS-1:0] n_rem;
    logic [ROOT_BITS-1:0]     n_root;

    // digit-by-digit root, one root bit per step
    always_comb begin
        logic [SQRT_REM_BITS+1:0] t;
        logic [SQRT_REM_BITS+1:0] trial;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        for (int k = 0; k < SQRT_STEPS_PER_CYCLE; k++) begin
            t     = {n_rem, n_rad[SUM_BITS-1 -: 2]};
            n_rad = {n_rad[SUM_BITS-3:0], 2'b00};
            trial = {2'b00, n_root, 2'b01};
            if (t >= trial) begin
                t      = t - trial;
                n_root = {n_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_root = {n_root[ROOT_BITS-2:0], 1'b0};
            end
            n_rem = t[SQRT_REM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQRT_CNT_BITS'(SQRT_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

/* tb/tb_block_rms_peak_to_peak_core.sv */
`default_nettype none

typedef struct packed {
    logic [rpp_pkg::CH_BITS-1:0]  channel;
    logic [rpp_pkg::OUT_BITS-1:0] rms;
    logic [rpp_pkg::OUT_BITS-1:0] p2p;
} t_rms_window;

class rms_window_scoreboard;
    longint unsigned           sum_sq[rpp_pkg::CHANNELS];
    int unsigned               n_seen[rpp_pkg::CHANNELS];
    logic signed [15:0]        win_hi[rpp_pkg::CHANNELS];
    logic signed [15:0]        win_lo[rpp_pkg::CHANNELS];
    logic [rpp_pkg::CNT_BITS-1:0] win_len;
    bit                        peak_en;
    t_rms_window               windows_due[$];
    int                        errors;

    function new();
        for (int i = 0; i < rpp_pkg::CHANNELS; i++) begin
            sum_sq[i] = 0;
            n_seen[i] = 0;
            win_hi[i] = '0;
            win_lo[i] = '0;
        end
        win_len = rpp_pkg::DEFAULT_WINDOW;
        peak_en = 1'b0;
        errors  = 0;
    endfunction

    function void set_reg(logic [rpp_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [rpp_pkg::CFG_DATA_BITS-1:0] data);
        if (idx == rpp_pkg::CFG_SAMPLE_COUNT) begin
            win_len = data[rpp_pkg::CNT_BITS-1:0];
        end else if (idx == rpp_pkg::CFG_SEND_PEAK) begin
            peak_en = data[0];
        end
    endfunction

    function longint unsigned int_root(longint unsigned v);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    function void note_sample(logic [rpp_pkg::CH_BITS-1:0] ch, logic signed [15:0] s);
        int unsigned     len;
        longint unsigned mean;
        longint unsigned root;
        longint          spread;
        t_rms_window     w;
        sum_sq[ch] += longint'(s) * longint'(s);
        if (n_seen[ch] == 0 || s > win_hi[ch]) win_hi[ch] = s;
        if (n_seen[ch] == 0 || s < win_lo[ch]) win_lo[ch] = s;
        n_seen[ch] = (n_seen[ch] + 1) & 32'hFFFF;
        len = (win_len == 0) ? 1 : win_len;
        if (n_seen[ch] < len) return;
        mean = sum_sq[ch] / len;
        root = int_root(mean);
        if (root > 65535) root = 65535;
        spread = peak_en ? longint'(win_hi[ch]) - longint'(win_lo[ch]) : 0;
        if (spread > 65535) spread = 65535;
        w.channel = ch;
        w.rms     = root[15:0];
        w.p2p     = spread[15:0];
        windows_due = {windows_due, w};
        sum_sq[ch] = 0;
        n_seen[ch] = 0;
    endfunction

    function void check_result(t_rms_window got);
        t_rms_window want;
        if (windows_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, got channel %0d rms %0d p2p %0d",
                     $time, got.channel, got.rms, got.p2p);
            errors++;
            return;
        end
        want = windows_due.pop_front();
        if (got.channel != want.channel) begin
            $display("%0t: channel_out: expected %0d, got %0d", $time, want.channel,
                     got.channel);
            errors++;
        end
        if (got.rms != want.rms) begin
            $display("%0t: rms_value (channel %0d): expected %0d, got %0d", $time,
                     want.channel, want.rms, got.rms);
            errors++;
        end
        if (got.p2p != want.p2p) begin
            $display("%0t: peak_to_peak (channel %0d): expected %0d, got %0d", $time,
                     want.channel, want.p2p, got.p2p);
            errors++;
        end
    endfunction

    function int pending();
        return windows_due.size();
    endfunction
endclass

module tb_block_rms_peak_to_peak_core;
    import rpp_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 88;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    rpp_in_if  in_ch ();
    rpp_out_if out_ch ();

    block_rms_peak_to_peak_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rms_window_scoreboard sb = new();

    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int stall_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // observe transactions on both channels
    always @(posedge clk) begin
        t_rms_window got;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.channel = out_ch.channel_out;
                got.rms     = out_ch.rms_value;
                got.p2p     = out_ch.peak_to_peak;
                sb.check_result(got);
            end
            if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.channel, in_ch.sample);
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result sink with random back-pressure and one long hold-off on request
    initial begin
        int gap;
        int hold;
        gap  = 0;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold         = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (gap > 0) begin
                out_ch.ready <= 1'b0;
                gap--;
            end else if (!no_idle && $urandom_range(0, 99) < rx_idle_pct) begin
                out_ch.ready <= 1'b0;
                gap = $urandom_range(1, 13) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [CH_BITS-1:0] ch, input logic signed [15:0] s);
        if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.channel <= ch;
        in_ch.sample  <= s;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic configure(input logic [CNT_BITS-1:0] len, input bit peak);
        logic [CFG_DATA_BITS-1:0] peak_word;
        peak_word = {15'($urandom()), peak};
        in_ch.valid <= 1'b0;
        // let the monitor log the last transaction before looking at the queue
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SAMPLE_COUNT;
        cfg_data <= len;
        @(posedge clk);
        sb.set_reg(CFG_SAMPLE_COUNT, len);
        cfg_idx  <= CFG_SEND_PEAK;
        cfg_data <= peak_word;
        @(posedge clk);
        sb.set_reg(CFG_SEND_PEAK, peak_word);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic signed [15:0]  first_window[10];
        logic signed [15:0]  corner_vals[4];
        logic [CNT_BITS-1:0] len_tab[PHASES];
        bit                  peak_tab[PHASES];
        logic [CH_BITS-1:0]  focus[3];
        logic [CH_BITS-1:0]  ch;
        logic signed [15:0]  s;

        first_window = '{32767, -32768, 0, -1, 1, 12345, -12345, 21845, -21846, 100};
        corner_vals  = '{32767, -32768, 0, -1};
        len_tab      = '{3, 1, 2, 5, 10, 1, 0, 4, 7, 2, 16, 3};
        peak_tab     = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 0, 1, 1};

        in_ch.valid   <= 1'b0;
        in_ch.channel <= '0;
        in_ch.sample  <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_SAMPLE_COUNT;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: window of ten, peak-to-peak forced to zero
        foreach (first_window[i]) send_sample(0, first_window[i]);

        configure(1, 1'b1);
        send_sample(63, -32768);
        send_sample(0, 32767);
        send_sample(42, 0);
        send_sample(21, -1);

        // zero window length behaves as one
        configure(0, 1'b1);
        send_sample(7, -5);
        send_sample(7, 300);

        // longest window, then shortened part way: emits on the next sample, saturated
        configure(16'hFFFF, 1'b1);
        send_sample(1, 32767);
        send_sample(1, -32768);
        send_sample(1, -32768);
        send_sample(1, -32768);
        configure(1, 1'b1);
        send_sample(1, -32768);

        for (int p = 0; p < PHASES; p++) begin
            configure(len_tab[p], peak_tab[p]);
            tx_idle_pct = (p % 4 == 3) ? 0 : $urandom_range(5, 40);
            rx_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 40);
            no_idle     = (p == PHASES - 1);
            foreach (focus[i]) focus[i] = CH_BITS'($urandom_range(0, CHANNELS - 1));
            if (p == 5) begin
                tx_idle_pct  = 0;
                hold_request = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    ch = focus[$urandom_range(0, 2)];
                end else begin
                    ch = CH_BITS'($urandom_range(0, CHANNELS - 1));
                end
                case ($urandom_range(0, 7))
                    0: begin
                        s = corner_vals[$urandom_range(0, 3)];
                    end
                    1, 2: begin
                        s = 16'(int'($urandom_range(0, 200)) - 100);
                    end
                    default: begin
                        s = 16'($urandom());
                    end
                endcase
                send_sample(ch, s);
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
src/rpp_pkg.sv
src/rpp_in_if.sv
src/rpp_out_if.sv
src/rpp_state_mem.sv
src/rpp_divider.sv
src/rpp_isqrt.sv
src/block_rms_peak_to_peak_core.sv
tb/tb_block_rms_peak_to_peak_core.sv
